// ===== rtl/core/lrc_ts_pkg.sv =====
// shared types and constants for the lrc timestamp parser
// parse phase enum, parser state and result structs, character codes and limits
// no dependencies
package lrc_ts_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MIN_FIRST,
        PH_MIN,
        PH_SEC_FIRST,
        PH_SEC,
        PH_FRAC
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [13:0] minutes;
        logic [6:0]  seconds;
        logic [9:0]  fraction;
        logic [1:0]  frac_digits;
    } parse_state_t;

    typedef struct packed {
        logic        emit;
        logic        status;
        logic [29:0] time_ms;
    } parse_result_t;

    localparam logic [7:0]  CHAR_OPEN   = 8'h5B;
    localparam logic [7:0]  CHAR_CLOSE  = 8'h5D;
    localparam logic [7:0]  CHAR_COLON  = 8'h3A;
    localparam logic [7:0]  CHAR_DOT    = 8'h2E;
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;
    localparam logic [7:0]  CHAR_NINE   = 8'h39;

    localparam logic [16:0] MAX_MINUTES   = 17'd9999;
    localparam logic [9:0]  MAX_SECONDS   = 10'd59;
    localparam logic [29:0] MS_PER_MINUTE = 30'd60000;
    localparam logic [29:0] MS_PER_SECOND = 30'd1000;
    localparam logic [1:0]  MAX_FRAC_DIGITS = 2'd3;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    localparam parse_state_t STATE_CLEAR = '{
        phase:       PH_IDLE,
        minutes:     14'd0,
        seconds:     7'd0,
        fraction:    10'd0,
        frac_digits: 2'd0
    };

endpackage

// ===== rtl/core/lrc_timestamp_parser.sv =====
// top level of the lrc timestamp parser: input register, parse step, result register
// uses lrc_ts_pkg and lrc_ts_step
//
// usage
// - slave channel: one character per transfer, s_tdata[7:0] is the character,
//   s_tuser is the start flag that abandons any attempt in progress
// - master channel: one transfer per finished timestamp; m_tdata[29:0] is the
//   time in milliseconds, m_tuser is the status (0 accepted, 1 rejected)
// - characters that close nothing (digits, separators, text while idle)
//   produce no master transfer
// - a result is valid at the master side once the character that completes it has
//   passed the input register and then the result register
// - throughput: one character per cycle while results are taken, set by the single
//   registered step of the parse state machine between input and result registers
// - reset (aresetn low, synchronous) empties both registers and puts the
//   parser back to idle with all accumulators cleared
// - when the receiver stalls with a result waiting, one more character is
//   held in the input register, after which s_tready drops until the result
//   is taken
module lrc_timestamp_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [29:0] time_ms, [31:30] zero
    output logic        m_tuser    // [0] status
);
    import lrc_ts_pkg::*;

    // input register
    logic          in_valid_reg;
    logic          in_valid_next;
    logic [7:0]    in_char_reg;
    logic          in_start_reg;

    // parse state
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_result;

    // result register
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [29:0]   out_time_reg;
    logic          out_status_reg;

    logic          out_free;
    logic          advance;

    // result slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;
    // held character is processed as soon as its result can be stored
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    lrc_ts_step u_step (
        .state_cur  (state_reg),
        .char_in    (in_char_reg),
        .start_req  (in_start_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = step_result.emit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_CLEAR;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (advance && step_result.emit) begin
            out_time_reg   <= step_result.time_ms;
            out_status_reg <= step_result.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'd0, out_time_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ===== rtl/core/lrc_ts_step.sv =====
// one character step of the timestamp parser: next phase, accumulators, result
// purely combinational; uses lrc_ts_pkg
module lrc_ts_step (
    input  lrc_ts_pkg::parse_state_t  state_cur,
    input  logic [7:0]                char_in,
    input  logic                      start_req,
    output lrc_ts_pkg::parse_state_t  state_next,
    output lrc_ts_pkg::parse_result_t result
);
    import lrc_ts_pkg::*;

    parse_state_t st;
    phase_t       phase_next;
    logic         is_digit;
    logic [3:0]   digit;
    logic [16:0]  min_v;
    logic [9:0]   sec_v;
    logic [9:0]   frac_v;
    logic [9:0]   frac_scaled;
    logic [29:0]  base_ms;
    logic         do_emit;
    logic         do_ok;

    // start abandons the attempt before this character is looked at
    assign st       = start_req ? STATE_CLEAR : state_cur;
    assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
    assign digit    = char_in[3:0];
    assign min_v    = {3'd0, st.minutes} * 17'd10 + {13'd0, digit};
    assign sec_v    = {3'd0, st.seconds} * 10'd10 + {6'd0, digit};
    assign frac_v   = st.fraction * 10'd10 + {6'd0, digit};
    assign base_ms  = {16'd0, st.minutes} * MS_PER_MINUTE
                    + {23'd0, st.seconds} * MS_PER_SECOND;

    always_comb begin
        case (st.frac_digits)
            2'd1:    frac_scaled = st.fraction * 10'd100;
            2'd2:    frac_scaled = st.fraction * 10'd10;
            2'd3:    frac_scaled = st.fraction;
            default: frac_scaled = 10'd0;
        endcase
    end

    // next phase and emit decision
    always_comb begin
        phase_next = st.phase;
        do_emit    = 1'b0;
        do_ok      = 1'b0;
        unique case (st.phase) inside
            PH_IDLE: begin
                if (char_in == CHAR_OPEN) begin
                    phase_next = PH_MIN_FIRST;
                end
            end
            PH_MIN_FIRST, PH_MIN: begin
                if (is_digit) begin
                    if (min_v > MAX_MINUTES) begin
                        do_emit = 1'b1;
                    end else begin
                        phase_next = PH_MIN;
                    end
                end else if (st.phase == PH_MIN && char_in == CHAR_COLON) begin
                    phase_next = PH_SEC_FIRST;
                end else begin
                    do_emit = 1'b1;
                end
            end
            PH_SEC_FIRST, PH_SEC: begin
                if (is_digit) begin
                    if (sec_v > MAX_SECONDS) begin
                        do_emit = 1'b1;
                    end else begin
                        phase_next = PH_SEC;
                    end
                end else if (st.phase == PH_SEC &&
                             (char_in == CHAR_DOT || char_in == CHAR_COLON)) begin
                    phase_next = PH_FRAC;
                end else if (st.phase == PH_SEC && char_in == CHAR_CLOSE) begin
                    do_emit = 1'b1;
                    do_ok   = 1'b1;
                end else begin
                    do_emit = 1'b1;
                end
            end
            PH_FRAC: begin
                if (is_digit) begin
                    phase_next = PH_FRAC;
                end else if (char_in == CHAR_CLOSE) begin
                    do_emit = 1'b1;
                    do_ok   = 1'b1;
                end else begin
                    do_emit = 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
        if (do_emit) begin
            phase_next = PH_IDLE;
        end
    end

    // accumulators and result
    always_comb begin
        state_next       = st;
        state_next.phase = phase_next;
        if (phase_next == PH_IDLE) begin
            // every way back to idle leaves the accumulators cleared
            state_next = STATE_CLEAR;
        end else begin
            case (st.phase) inside
                PH_MIN_FIRST, PH_MIN: begin
                    if (is_digit) begin
                        state_next.minutes = min_v[13:0];
                    end
                end
                PH_SEC_FIRST, PH_SEC: begin
                    if (is_digit) begin
                        state_next.seconds = sec_v[6:0];
                    end
                end
                PH_FRAC: begin
                    // digits past the third are dropped
                    if (is_digit && st.frac_digits != MAX_FRAC_DIGITS) begin
                        state_next.fraction    = frac_v;
                        state_next.frac_digits = st.frac_digits + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
        result.emit    = do_emit;
        result.status  = do_ok ? STATUS_OK : STATUS_REJECT;
        result.time_ms = do_ok ? base_ms + {20'd0, frac_scaled} : 30'd0;
    end

endmodule

// ===== rtl/core/lrc_ts_checker.sv =====
// port-level checks for the lrc timestamp parser, bound to the top level
// sees only the ports of lrc_timestamp_parser
module lrc_ts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a reject carries a zero time
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("reject with nonzero time");

    // an accepted time stays within the largest timestamp
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata <= 32'd599999999)
        else $error("time out of range");

    // input only backs up behind a waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty result slot");

    // reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind lrc_timestamp_parser lrc_ts_checker u_lrc_ts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
